>>> rtl/c32za_pkg.sv
// Package: widths, GF(2) matrix type and the zero-byte operator table builder.
package c32za_pkg;

    localparam int unsigned CRC_W      = 32;
    localparam int unsigned CNT_W      = 63;
    localparam int unsigned COUNT_BITS = 64;
    // one pipeline stage per count bit that can be set
    localparam int unsigned STAGES     = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hedb8_8320;

    typedef logic [CRC_W-1:0]            t_crc;
    typedef logic [CNT_W-1:0]            t_cnt;
    // row i is the image of register bit i
    typedef logic [CRC_W-1:0][CRC_W-1:0] t_mat;

    function automatic t_crc mat_apply(input t_mat m, input t_crc v);
        t_crc acc;
        acc = '0;
        for (int i = 0; i < CRC_W; i++) begin
            if (v[i]) begin
                acc = acc ^ m[i];
            end
        end
        return acc;
    endfunction

    function automatic t_mat mat_square(input t_mat m);
        t_mat d;
        for (int i = 0; i < CRC_W; i++) begin
            d[i] = mat_apply(m, m[i]);
        end
        return d;
    endfunction

    // operator for 2^n zero bytes; evaluated at elaboration only
    function automatic t_mat zero_op(input int unsigned n);
        t_mat a;
        a[0] = CRC_POLY;
        for (int i = 1; i < CRC_W; i++) begin
            a[i] = t_crc'(1) << (i - 1);
        end
        // one bit -> two -> four -> eight bits (one byte)
        for (int s = 0; s < 3; s++) begin
            a = mat_square(a);
        end
        for (int unsigned s = 0; s < n; s++) begin
            a = mat_square(a);
        end
        return a;
    endfunction

endpackage

>>> rtl/c32za_in_if.sv
// Input channel: CRC register and zero-byte count, valid/ready handshake.
interface c32za_in_if import c32za_pkg::*; ();
    logic valid;
    logic ready;
    t_crc crc_in;
    t_cnt zero_byte_count;

    modport source (output valid, output crc_in, output zero_byte_count, input ready);
    modport sink   (input valid, input crc_in, input zero_byte_count, output ready);
endinterface

>>> rtl/c32za_out_if.sv
// Output channel: advanced CRC register, valid/ready handshake.
interface c32za_out_if import c32za_pkg::*; ();
    logic valid;
    logic ready;
    t_crc crc_out;

    modport source (output valid, output crc_out, input ready);
    modport sink   (input valid, input crc_out, output ready);
endinterface

>>> rtl/c32za_stage.sv
// One pipeline stage: applies its zero-byte matrix when its count bit is set.
module c32za_stage import c32za_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_mat i_mat,
    input  logic i_sel,
    input  logic i_vld,
    input  t_crc i_crc,
    input  t_cnt i_cnt,
    output logic o_vld,
    output t_crc o_crc,
    output t_cnt o_cnt
);

    logic r_vld;
    t_crc r_crc;
    t_cnt r_cnt;
    t_crc n_crc;

    always_comb begin
        n_crc = i_sel ? mat_apply(i_mat, i_crc) : i_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_crc <= n_crc;
            r_cnt <= i_cnt;
        end
    end

    assign o_vld = r_vld;
    assign o_crc = r_crc;
    assign o_cnt = r_cnt;

endmodule

>>> rtl/crc32_zero_byte_advance_top.sv
// Top level: CRC-32 zero-byte advance as a pipeline of constant GF(2) matrix stages.
//
//  channel  | dir | beat payload                       | handshake
//  ---------+-----+------------------------------------+-------------
//  i_in     | in  | crc_in[31:0], zero_byte_count[62:0]| valid/ready
//  o_out    | out | crc_out[31:0]                      | valid/ready
//
// There is one register stage per count bit, each stage one 32x32
// constant XOR network. One beat enters per cycle unless o_out stalls.
// Reset (i_rst_n low, synchronous) clears only the stage valid bits.
// A stall on o_out freezes the whole pipeline at once; i_in.ready drops
// in the same cycle, so nothing is lost or repeated.
module crc32_zero_byte_advance_top import c32za_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    c32za_in_if.sink    i_in,
    c32za_out_if.source o_out
);

    // stage k reads slot k and writes slot k+1; slot 0 is the input port
    logic       w_vld [0:STAGES];
    t_crc       w_crc [0:STAGES];
    t_cnt       w_cnt [0:STAGES];
    logic       w_en;

    // global advance: the last stage is the output register
    assign w_en       = !w_vld[STAGES] || o_out.ready;
    assign i_in.ready = w_en;

    assign w_vld[0] = i_in.valid;
    assign w_crc[0] = i_in.crc_in;
    assign w_cnt[0] = i_in.zero_byte_count;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        // operator for 2^k zero bytes, folded to constants at elaboration
        localparam t_mat M = zero_op(k);

        c32za_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_mat   (M),
            .i_sel   (w_cnt[k][k]),
            .i_vld   (w_vld[k]),
            .i_crc   (w_crc[k]),
            .i_cnt   (w_cnt[k]),
            .o_vld   (w_vld[k+1]),
            .o_crc   (w_crc[k+1]),
            .o_cnt   (w_cnt[k+1])
        );
    end

    assign o_out.valid   = w_vld[STAGES];
    assign o_out.crc_out = w_crc[STAGES];

endmodule
